// File: hw/rtl/prr_pkg.sv
// ----------------------------------------------------------------------------
// prr_pkg
// shared constants, codes and interface types of the rational resampler
// ----------------------------------------------------------------------------
package prr_pkg;

    localparam int SAMPLE_BITS     = 16;
    localparam int COEF_BITS       = 18;
    localparam int MAX_HALF        = 128;
    localparam int MAX_PHASE_COUNT = 256;
    localparam int RING_DEPTH      = 2 * MAX_HALF;
    localparam int BANK_DEPTH      = MAX_PHASE_COUNT * RING_DEPTH;
    localparam int MAX_RESULTS     = 64;

    localparam int CNT_W  = 40;   // samples received
    localparam int OUT_W  = 49;   // outputs made, end index
    localparam int PROD_W = 66;   // a*b+addend of the mul/div unit
    localparam int OPA_W  = 49;
    localparam int OPB_W  = 16;
    localparam int ACC_W  = 44;

    localparam logic [CNT_W-1:0] COUNT_LIMIT = {CNT_W{1'b1}};

    typedef enum logic [1:0] {
        FUNC_SAMPLE = 2'd0,
        FUNC_COEF   = 2'd1,
        FUNC_FLUSH  = 2'd2,
        FUNC_NONE   = 2'd3
    } func_t;

    typedef enum logic [1:0] {
        REG_UP   = 2'd0,
        REG_DOWN = 2'd1,
        REG_HALF = 2'd2,
        REG_NONE = 2'd3
    } reg_idx_t;

    // (a*b + addend) / divisor
    typedef struct packed {
        logic              start;
        logic [OPA_W-1:0]  a;
        logic [OPB_W-1:0]  b;
        logic [OPB_W-1:0]  addend;
        logic [OPB_W-1:0]  divisor;
    } prr_md_req_t;

    typedef struct packed {
        logic              done;
        logic [PROD_W-1:0] quot;
        logic [OPB_W-1:0]  rem;
    } prr_md_rsp_t;

endpackage

// File: hw/rtl/polyphase_rational_resampler_unit.sv
// ----------------------------------------------------------------------------
// polyphase_rational_resampler_unit
// rational L/M polyphase fir resampler with coefficient bank and history ring
// ----------------------------------------------------------------------------
//  channel  | signals                       | content
//  ---------+-------------------------------+-----------------------------------
//  in       | s_tvalid s_tready s_tdata     | func in tuser; sample, coef_addr,
//           | s_tuser                       | coef_value in tdata
//  out      | m_tvalid m_tready m_tdata     | out_sample in tdata, last in tlast,
//           | m_tlast m_tuser               | empty_res in tuser
//  config   | cfg_we cfg_index cfg_data     | 0 up_factor, 1 down_factor,
//           |                               | 2 half_taps
//
//  one item at a time; a flush, or a sample once the count exceeds half_taps,
//  gets its end index from the mul/div unit, then each output its position
//  there and a mac of 2*half_taps taps over the two memories
//  a coefficient write is stored directly; the history ring is cleared by
//  the sample count (reads past the count give zero), so no clearing pass
//  a stalled output holds the sequencer before the next result
// ----------------------------------------------------------------------------
module polyphase_rational_resampler_unit (
    input  logic        clk,
    input  logic        rst_n,
    // input transfers
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [55:0] s_tdata,   // sample[15:0], coef_addr[31:16], coef_value[49:32]
    input  logic [1:0]  s_tuser,   // func
    // result transfers
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // out_sample
    output logic        m_tlast,
    output logic        m_tuser,   // empty_res
    // configuration
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data
);
    import prr_pkg::*;

    localparam int RING_AW = $clog2(RING_DEPTH);
    localparam int BANK_AW = $clog2(BANK_DEPTH);
    localparam int PHASE_W = $clog2(MAX_PHASE_COUNT);
    localparam int TAP_W   = $clog2(RING_DEPTH + 1);
    localparam int N_W     = $clog2(MAX_RESULTS + 1);
    localparam int K_W     = PROD_W + 1;
    localparam int PRD_W   = SAMPLE_BITS + COEF_BITS;

    typedef enum logic [7:0] {
        S_IDLE  = 8'b0000_0001,
        S_END   = 8'b0000_0010,
        S_CHECK = 8'b0000_0100,
        S_LOC   = 8'b0000_1000,
        S_MAC   = 8'b0001_0000,
        S_DRAIN = 8'b0010_0000,
        S_OUT   = 8'b0100_0000,
        S_EMPTY = 8'b1000_0000
    } seq_state_t;

    // configuration registers
    logic [8:0]  up_reg;
    logic [15:0] down_reg;
    logic [7:0]  half_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            up_reg   <= 9'd1;
            down_reg <= 16'd1;
            half_reg <= 8'd24;
        end
        else if (cfg_we)
        begin
            case (reg_idx_t'(cfg_index))
                REG_UP:   up_reg   <= cfg_data[8:0];
                REG_DOWN: down_reg <= cfg_data;
                REG_HALF: half_reg <= cfg_data[7:0];
                default:  ;
            endcase
        end
    end

    // effective factors: zero taken as one, L and half_taps clamped to what the bank holds
    logic [8:0]  l_eff;
    logic [15:0] m_eff;
    logic [7:0]  h_eff;

    assign l_eff = (up_reg == '0) ? 9'd1 :
                   (up_reg > 9'(MAX_PHASE_COUNT)) ? 9'(MAX_PHASE_COUNT) : up_reg;
    assign m_eff = (down_reg == '0) ? 16'd1 : down_reg;
    assign h_eff = (half_reg == '0) ? 8'd1 :
                   (half_reg > 8'(MAX_HALF)) ? 8'(MAX_HALF) : half_reg;

    // input fields
    func_t                  in_func;
    logic [SAMPLE_BITS-1:0] in_sample;
    logic [15:0]            in_coef_addr;
    logic [COEF_BITS-1:0]   in_coef_value;

    assign in_func       = func_t'(s_tuser);
    assign in_sample     = s_tdata[15:0];
    assign in_coef_addr  = s_tdata[31:16];
    assign in_coef_value = s_tdata[49:32];

    // sequencer state
    seq_state_t         state_reg, state_next;
    logic [CNT_W-1:0]   samples_reg, samples_next;
    logic [OUT_W-1:0]   outputs_reg, outputs_next;
    logic [OUT_W-1:0]   end_reg, end_next;
    logic [N_W-1:0]     n_reg, n_next;
    logic               flush_done_reg, flush_done_next;
    logic               flush_mode_reg, flush_mode_next;
    logic [PHASE_W-1:0] phase_reg, phase_next;
    logic signed [K_W-1:0] k_reg, k_next;
    logic [TAP_W-1:0]   t_reg, t_next;

    // mac pipeline
    logic                     iss_v1_reg, hv1_reg, v2_reg;
    logic signed [PRD_W-1:0]  prod_reg;
    logic signed [ACC_W-1:0]  acc_reg;
    logic                     acc_clr;

    // output register
    logic                   out_valid_reg, out_valid_next;
    logic [SAMPLE_BITS-1:0] out_data_reg, out_data_next;
    logic                   out_last_reg, out_last_next;
    logic                   out_empty_reg, out_empty_next;

    logic in_xfer, out_free, hist_valid;
    logic [CNT_W-1:0] samples_inc;
    logic [CNT_W-1:0] b1;
    logic [SAMPLE_BITS-1:0] rounded;

    prr_md_req_t md_req;
    prr_md_rsp_t md_rsp;

    logic ring_we, coef_we;
    logic [SAMPLE_BITS-1:0] ring_rdata;
    logic [COEF_BITS-1:0]   coef_rdata;

    assign s_tready    = (state_reg == S_IDLE);
    assign in_xfer     = s_tvalid && s_tready;
    assign out_free    = !out_valid_reg || m_tready;
    assign samples_inc = samples_reg + 1'b1;
    assign b1          = samples_inc - CNT_W'(h_eff);
    assign hist_valid  = !k_reg[K_W-1] && (k_reg[K_W-2:0] < (K_W-1)'(samples_reg));

    assign ring_we = in_xfer && (in_func == FUNC_SAMPLE) && !flush_done_reg
                     && (samples_reg != COUNT_LIMIT);
    assign coef_we = in_xfer && (in_func == FUNC_COEF);

    // history ring: written at the sample count, read at the window index
    prr_ram #(
        .WIDTH (SAMPLE_BITS),
        .DEPTH (RING_DEPTH)
    ) u_ring (
        .clk   (clk),
        .we    (ring_we),
        .waddr (samples_reg[RING_AW-1:0]),
        .wdata (in_sample),
        .raddr (k_reg[RING_AW-1:0]),
        .rdata (ring_rdata)
    );

    // coefficient bank: phase in the upper bits, tap in the lower
    prr_ram #(
        .WIDTH (COEF_BITS),
        .DEPTH (BANK_DEPTH)
    ) u_bank (
        .clk   (clk),
        .we    (coef_we),
        .waddr (in_coef_addr[BANK_AW-1:0]),
        .wdata (in_coef_value),
        .raddr ({phase_reg, t_reg[RING_AW-1:0]}),
        .rdata (coef_rdata)
    );

    prr_muldiv u_muldiv (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (md_req),
        .rsp   (md_rsp)
    );

    // round half up at bit 16, floor, saturate to the sample width
    logic signed [ACC_W-1:0]            acc_rnd;
    logic signed [ACC_W-COEF_BITS:0]    acc_q;

    assign acc_rnd = acc_reg + (ACC_W'(1) <<< (COEF_BITS - 2));
    assign acc_q   = acc_rnd[ACC_W-1:COEF_BITS-1];

    always_comb
    begin
        if (acc_q > (ACC_W-COEF_BITS+1)'(2**(SAMPLE_BITS-1) - 1))
        begin
            rounded = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
        end
        else if (acc_q < -(ACC_W-COEF_BITS+1)'(2**(SAMPLE_BITS-1)))
        begin
            rounded = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
        end
        else
        begin
            rounded = acc_q[SAMPLE_BITS-1:0];
        end
    end

    // sequencer
    always_comb
    begin
        state_next      = state_reg;
        samples_next    = samples_reg;
        outputs_next    = outputs_reg;
        end_next        = end_reg;
        n_next          = n_reg;
        flush_done_next = flush_done_reg;
        flush_mode_next = flush_mode_reg;
        phase_next      = phase_reg;
        k_next          = k_reg;
        t_next          = t_reg;
        acc_clr         = 1'b0;
        out_valid_next  = out_valid_reg && !m_tready;
        out_data_next   = out_data_reg;
        out_last_next   = out_last_reg;
        out_empty_next  = out_empty_reg;
        md_req.start    = 1'b0;
        md_req.a        = OPA_W'(b1);
        md_req.b        = OPB_W'(l_eff);
        md_req.addend   = m_eff - 1'b1;
        md_req.divisor  = m_eff;

        case (state_reg)
            S_IDLE:
            begin
                if (in_xfer)
                begin
                    case (in_func)
                        FUNC_SAMPLE:
                        begin
                            if (ring_we)
                            begin
                                samples_next    = samples_inc;
                                flush_mode_next = 1'b0;
                                n_next          = '0;
                                // end index ceil((count-half)*L/M) once positive
                                if (samples_inc > CNT_W'(h_eff))
                                begin
                                    md_req.start = 1'b1;
                                    state_next   = S_END;
                                end
                                else
                                begin
                                    end_next   = '0;
                                    state_next = S_CHECK;
                                end
                            end
                        end
                        FUNC_FLUSH:
                        begin
                            if (flush_done_reg)
                            begin
                                state_next = S_EMPTY;
                            end
                            else
                            begin
                                flush_done_next = 1'b1;
                                flush_mode_next = 1'b1;
                                n_next          = '0;
                                md_req.start    = 1'b1;
                                md_req.a        = OPA_W'(samples_reg);
                                state_next      = S_END;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_END:
            begin
                if (md_rsp.done)
                begin
                    end_next   = md_rsp.quot[OUT_W-1:0];
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                if ((outputs_reg < end_reg) && (n_reg < N_W'(MAX_RESULTS)))
                begin
                    // position of output j: floor(j*M/L) and phase j*M mod L
                    md_req.start   = 1'b1;
                    md_req.a       = outputs_reg;
                    md_req.b       = m_eff;
                    md_req.addend  = '0;
                    md_req.divisor = OPB_W'(l_eff);
                    state_next     = S_LOC;
                end
                else
                begin
                    // outputs past the result limit are skipped
                    if (end_reg > outputs_reg)
                    begin
                        outputs_next = end_reg;
                    end
                    state_next = (flush_mode_reg && (n_reg == '0)) ? S_EMPTY : S_IDLE;
                end
            end
            S_LOC:
            begin
                if (md_rsp.done)
                begin
                    phase_next = md_rsp.rem[PHASE_W-1:0];
                    k_next     = signed'({1'b0, md_rsp.quot}) - K_W'(h_eff) + 1'b1;
                    t_next     = '0;
                    acc_clr    = 1'b1;
                    state_next = S_MAC;
                end
            end
            S_MAC:
            begin
                k_next = k_reg + 1'b1;
                t_next = t_reg + 1'b1;
                if (t_reg == TAP_W'({h_eff, 1'b0} - 1'b1))
                begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                if (!iss_v1_reg && !v2_reg)
                begin
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = rounded;
                    out_last_next  = ((outputs_reg + 1'b1) == end_reg)
                                     || (n_reg == N_W'(MAX_RESULTS - 1));
                    out_empty_next = 1'b0;
                    outputs_next   = outputs_reg + 1'b1;
                    n_next         = n_reg + 1'b1;
                    state_next     = S_CHECK;
                end
            end
            S_EMPTY:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = '0;
                    out_last_next  = 1'b1;
                    out_empty_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            samples_reg    <= '0;
            outputs_reg    <= '0;
            end_reg        <= '0;
            n_reg          <= '0;
            flush_done_reg <= 1'b0;
            flush_mode_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            iss_v1_reg     <= 1'b0;
            v2_reg         <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            samples_reg    <= samples_next;
            outputs_reg    <= outputs_next;
            end_reg        <= end_next;
            n_reg          <= n_next;
            flush_done_reg <= flush_done_next;
            flush_mode_reg <= flush_mode_next;
            out_valid_reg  <= out_valid_next;
            iss_v1_reg     <= (state_reg == S_MAC);
            v2_reg         <= iss_v1_reg;
        end
    end

    // payload and mac datapath
    always_ff @(posedge clk)
    begin
        phase_reg     <= phase_next;
        k_reg         <= k_next;
        t_reg         <= t_next;
        hv1_reg       <= hist_valid;
        out_data_reg  <= out_data_next;
        out_last_reg  <= out_last_next;
        out_empty_reg <= out_empty_next;
        // taps outside the received stream count as zero
        prod_reg      <= hv1_reg ? signed'(ring_rdata) * signed'(coef_rdata) : PRD_W'(0);
        if (acc_clr)
        begin
            acc_reg <= '0;
        end
        else if (v2_reg)
        begin
            acc_reg <= acc_reg + ACC_W'(prod_reg);
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tlast  = out_last_reg;
    assign m_tuser  = out_empty_reg;

endmodule

// File: hw/rtl/prr_ram.sv
// ----------------------------------------------------------------------------
// prr_ram
// generic single-port-write, single-port-read ram with registered read
// ----------------------------------------------------------------------------
module prr_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// File: hw/rtl/prr_muldiv.sv
// ----------------------------------------------------------------------------
// prr_muldiv
// sequential (a*b + addend) / divisor: shift-add multiply, restoring divide
// ----------------------------------------------------------------------------
module prr_muldiv (
    input  logic                clk,
    input  logic                rst_n,
    input  prr_pkg::prr_md_req_t req,
    output prr_pkg::prr_md_rsp_t rsp
);
    import prr_pkg::*;

    localparam int MUL_STEPS = OPB_W;
    localparam int DIV_STEPS = PROD_W;
    localparam int STEP_W    = $clog2(DIV_STEPS + 1);

    typedef enum logic [2:0] {
        M_IDLE = 3'b001,
        M_MUL  = 3'b010,
        M_DIV  = 3'b100
    } md_state_t;

    md_state_t         state_reg, state_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic [PROD_W-1:0] prod_reg, prod_next;
    logic [PROD_W-1:0] mcand_reg, mcand_next;
    logic [OPB_W-1:0]  mplier_reg, mplier_next;
    logic [OPB_W-1:0]  div_reg, div_next;
    logic [OPB_W-1:0]  rem_reg, rem_next;
    logic              done_reg, done_next;
    logic [OPB_W:0]    trial;
    logic              qbit;

    assign trial = {rem_reg, prod_reg[PROD_W-1]};
    assign qbit  = (trial >= {1'b0, div_reg});

    always_comb
    begin
        state_next  = state_reg;
        step_next   = step_reg;
        prod_next   = prod_reg;
        mcand_next  = mcand_reg;
        mplier_next = mplier_reg;
        div_next    = div_reg;
        rem_next    = rem_reg;
        done_next   = 1'b0;
        case (state_reg)
            M_IDLE:
            begin
                if (req.start)
                begin
                    prod_next   = PROD_W'(req.addend);
                    mcand_next  = PROD_W'(req.a);
                    mplier_next = req.b;
                    div_next    = req.divisor;
                    rem_next    = '0;
                    step_next   = STEP_W'(MUL_STEPS - 1);
                    state_next  = M_MUL;
                end
            end
            M_MUL:
            begin
                if (mplier_reg[0])
                begin
                    prod_next = prod_reg + mcand_reg;
                end
                mcand_next  = {mcand_reg[PROD_W-2:0], 1'b0};
                mplier_next = {1'b0, mplier_reg[OPB_W-1:1]};
                if (step_reg == '0)
                begin
                    step_next  = STEP_W'(DIV_STEPS - 1);
                    state_next = M_DIV;
                end
                else
                begin
                    step_next = step_reg - 1'b1;
                end
            end
            M_DIV:
            begin
                rem_next  = qbit ? OPB_W'(trial - {1'b0, div_reg}) : trial[OPB_W-1:0];
                prod_next = {prod_reg[PROD_W-2:0], qbit};
                if (step_reg == '0)
                begin
                    done_next  = 1'b1;
                    state_next = M_IDLE;
                end
                else
                begin
                    step_next = step_reg - 1'b1;
                end
            end
            default:
            begin
                state_next = M_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= M_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        step_reg   <= step_next;
        prod_reg   <= prod_next;
        mcand_reg  <= mcand_next;
        mplier_reg <= mplier_next;
        div_reg    <= div_next;
        rem_reg    <= rem_next;
    end

    assign rsp.done = done_reg;
    assign rsp.quot = prod_reg;
    assign rsp.rem  = rem_reg;

endmodule

// File: hw/rtl/prr_checker.sv
// ----------------------------------------------------------------------------
// prr_checker
// port-level checks of the rational resampler, bound to the top level
// ----------------------------------------------------------------------------
module prr_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [1:0]  s_tuser,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata,
    input logic        m_tlast,
    input logic        m_tuser
);
    import prr_pkg::*;

    // an empty flush result is always the last one and carries zero
    a_empty_last: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser) |-> (m_tlast && (m_tdata == '0)))
        else $error("empty result without last or with data");

    // a flush always produces a result, so the input side is busy right after
    a_flush_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready && (s_tuser == FUNC_FLUSH)) |=> !s_tready)
        else $error("input ready right after flush transfer");

    // after a flush transfer, an empty result never follows straight on an empty result just taken
    a_flush_no_same_cycle: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready && (s_tuser == FUNC_FLUSH)) |=> !(m_tvalid && m_tuser
            && $past(m_tvalid && m_tready && m_tuser)))
        else $error("empty result repeated back to back");

    // stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)
            && $stable(m_tlast) && $stable(m_tuser)))
        else $error("result changed while stalled");

endmodule

bind polyphase_rational_resampler_unit prr_checker u_prr_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
);
